>>> hdl/pld_pkg.sv
// Shared types and constants for the packet length deframer.
package pld_pkg;

    localparam logic [7:0]  HDR_LONG_MARK  = 8'd160;
    localparam logic [14:0] SIZE_LONG_MARK = 15'd160;
    localparam logic [14:0] SIZE_ONE       = 15'd1;
    localparam logic [14:0] SIZE_ZERO      = 15'd0;
    localparam int          QUEUE_DEPTH    = 4;
    localparam int          QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int          QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QUEUE_CW-1:0] QUEUE_ROOM_LIMIT = QUEUE_CW'(QUEUE_DEPTH - 2);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        packet_start;
        logic        packet_end;
        logic [14:0] packet_size;
        logic        framing_error;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

>>> hdl/pld_decoder.sv
// Input register, header decode and packet state for the deframer.
module pld_decoder
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           stream_valid,
    output logic           stream_stall,
    input  logic [7:0]     stream_byte,
    input  logic           room,
    output pld_pkg::push_t push
);

    logic              full_reg, full_next;
    logic [7:0]        byte_reg;
    pld_pkg::phase_t   phase_reg, phase_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        held_reg, held_next;
    logic [14:0]       left_reg, left_next;
    logic              short_reg, short_next;
    logic              start_reg, start_next;
    logic [14:0]       size_reg, size_next;

    logic              proceed;
    logic              accept;
    logic              hdr_long;
    logic [7:0]        hdr_hi;
    logic [14:0]       hdr_len;
    logic [14:0]       left_eff;
    logic [14:0]       left_dec;
    logic              body_last;

    assign proceed      = full_reg & room;
    assign stream_stall = full_reg & ~room;
    assign accept       = stream_valid & ~stream_stall;

    assign hdr_long  = (first_reg >= pld_pkg::HDR_LONG_MARK);
    assign hdr_hi    = first_reg - pld_pkg::HDR_LONG_MARK;
    assign hdr_len   = hdr_long ? {hdr_hi[6:0], byte_reg} : {7'd0, first_reg};
    assign left_eff  = (left_reg == pld_pkg::SIZE_ZERO) ? pld_pkg::SIZE_ONE : left_reg;
    assign left_dec  = left_eff - pld_pkg::SIZE_ONE;
    assign body_last = (left_dec == pld_pkg::SIZE_ZERO);

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (proceed)
        begin
            full_next = 1'b0;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (proceed)
        begin
            case (phase_reg)
                pld_pkg::PH_FIRST:
                begin
                    phase_next = pld_pkg::PH_SECOND;
                end
                pld_pkg::PH_SECOND:
                begin
                    if (hdr_len == pld_pkg::SIZE_ZERO)
                    begin
                        phase_next = pld_pkg::PH_HALT;
                    end
                    else if (hdr_len == pld_pkg::SIZE_ONE)
                    begin
                        phase_next = pld_pkg::PH_FIRST;
                    end
                    else
                    begin
                        phase_next = pld_pkg::PH_BODY;
                    end
                end
                pld_pkg::PH_BODY:
                begin
                    if (body_last)
                    begin
                        phase_next = pld_pkg::PH_FIRST;
                    end
                end
                default:
                begin
                    phase_next = pld_pkg::PH_HALT;
                end
            endcase
        end
    end

    // results and packet state
    always_comb
    begin
        first_next = first_reg;
        held_next  = held_reg;
        left_next  = left_reg;
        short_next = short_reg;
        start_next = start_reg;
        size_next  = size_reg;
        push       = '0;
        if (proceed)
        begin
            case (phase_reg)
                pld_pkg::PH_FIRST:
                begin
                    first_next = byte_reg;
                end
                pld_pkg::PH_SECOND:
                begin
                    if (hdr_len == pld_pkg::SIZE_ZERO)
                    begin
                        push.v0               = 1'b1;
                        push.r0.framing_error = 1'b1;
                    end
                    else
                    begin
                        size_next  = hdr_len;
                        start_next = 1'b1;
                        if (hdr_len < pld_pkg::SIZE_LONG_MARK)
                        begin
                            short_next = 1'b1;
                            held_next  = byte_reg;
                            if (hdr_len == pld_pkg::SIZE_ONE)
                            begin
                                push.v0              = 1'b1;
                                push.r0.payload_byte = byte_reg;
                                push.r0.packet_start = 1'b1;
                                push.r0.packet_end   = 1'b1;
                                push.r0.packet_size  = hdr_len;
                                start_next           = 1'b0;
                                left_next            = pld_pkg::SIZE_ZERO;
                            end
                            else
                            begin
                                left_next = hdr_len - pld_pkg::SIZE_ONE;
                            end
                        end
                        else
                        begin
                            short_next = 1'b0;
                            left_next  = hdr_len;
                        end
                    end
                end
                pld_pkg::PH_BODY:
                begin
                    left_next            = left_dec;
                    start_next           = 1'b0;
                    push.v0              = 1'b1;
                    push.r0.payload_byte = byte_reg;
                    push.r0.packet_start = start_reg;
                    push.r0.packet_end   = body_last & ~short_reg;
                    push.r0.packet_size  = size_reg;
                    if (body_last && short_reg)
                    begin
                        push.v1              = 1'b1;
                        push.r1.payload_byte = held_reg;
                        push.r1.packet_end   = 1'b1;
                        push.r1.packet_size  = size_reg;
                    end
                end
                default:
                begin
                    push = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= 1'b0;
            phase_reg <= pld_pkg::PH_FIRST;
            left_reg  <= '0;
            short_reg <= 1'b0;
            start_reg <= 1'b0;
            size_reg  <= '0;
            first_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            full_reg  <= full_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
            short_reg <= short_next;
            start_reg <= start_next;
            size_reg  <= size_next;
            first_reg <= first_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= stream_byte;
        end
    end

`ifndef SYNTH
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pld_pkg::PH_HALT) |-> !push.v0)
        else $error("result pushed while halted");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> (push.v0 && push.r0.packet_end == 1'b0 && push.r1.packet_end))
        else $error("held byte pushed without closing streamed byte");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (push.v0 && push.r0.framing_error) |=> (phase_reg == pld_pkg::PH_HALT))
        else $error("framing error did not halt the block");
`endif

endmodule

>>> hdl/pld_out_queue.sv
// Result queue that parts the decoder from the output channel.
module pld_out_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  pld_pkg::push_t push,
    output logic           room,
    output logic           payload_valid,
    input  logic           payload_stall,
    output logic [7:0]     payload_byte,
    output logic           packet_start,
    output logic           packet_end,
    output logic [14:0]    packet_size,
    output logic           framing_error
);

    pld_pkg::result_t                 mem_reg [pld_pkg::QUEUE_DEPTH];
    logic [pld_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pld_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pld_pkg::QUEUE_CW-1:0]     count_reg, count_next;
    logic [pld_pkg::QUEUE_AW-1:0]     wr_ptr_1;
    logic                             pop;
    logic [pld_pkg::QUEUE_CW-1:0]     n_push;
    pld_pkg::result_t                 head;

    assign room          = (count_reg <= pld_pkg::QUEUE_ROOM_LIMIT);
    assign payload_valid = (count_reg != '0);
    assign pop           = payload_valid & ~payload_stall;
    assign wr_ptr_1      = wr_ptr_reg + pld_pkg::QUEUE_AW'(1);
    assign n_push        = pld_pkg::QUEUE_CW'(push.v0) + pld_pkg::QUEUE_CW'(push.v1);

    assign head          = mem_reg[rd_ptr_reg];
    assign payload_byte  = head.payload_byte;
    assign packet_start  = head.packet_start;
    assign packet_end    = head.packet_end;
    assign packet_size   = head.packet_size;
    assign framing_error = head.framing_error;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + pld_pkg::QUEUE_AW'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + pld_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + n_push - pld_pkg::QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_1] <= push.r1;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pld_pkg::QUEUE_CW'(pld_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> room)
        else $error("result pushed without room");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop && !push.v0) |=> $stable(count_reg))
        else $error("queue fill changed without push or pop");
`endif

endmodule

>>> hdl/packet_length_deframer_core.sv
// Top level of the packet length deframer.
// Takes one stream byte per cycle while the result queue has room and hands out packet
// bytes with start, end and size marks. Each byte passes an input register and a single
// decode step into a four-entry result queue; the byte that closes a short-form packet
// yields two results, and as the queue hands out one result per cycle when not stalled,
// the input is then held while it lacks room. A zero length yields one item flagged
// framing_error, after which input bytes are taken and dropped until reset.
module packet_length_deframer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stream_valid,
    output logic        stream_stall,
    input  logic [7:0]  stream_byte,
    output logic        payload_valid,
    input  logic        payload_stall,
    output logic [7:0]  payload_byte,
    output logic        packet_start,
    output logic        packet_end,
    output logic [14:0] packet_size,
    output logic        framing_error
);

    pld_pkg::push_t push;
    logic           room;

    pld_decoder u_decoder
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .stream_byte  (stream_byte),
        .room         (room),
        .push         (push)
    );

    pld_out_queue u_out_queue
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .room          (room),
        .payload_valid (payload_valid),
        .payload_stall (payload_stall),
        .payload_byte  (payload_byte),
        .packet_start  (packet_start),
        .packet_end    (packet_end),
        .packet_size   (packet_size),
        .framing_error (framing_error)
    );

endmodule
